// ===== hw/rtl/depth_pixel_back_projection_macros.svh =====
// Assertion helpers for the top-level RTL file, depth_pixel_back_projection.sv.
`ifndef DEPTH_PIXEL_BACK_PROJECTION_MACROS_SVH
`define DEPTH_PIXEL_BACK_PROJECTION_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DPBP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define DPBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dpbp_pkg.sv =====
package dpbp_pkg;

  localparam int unsigned ROW_W   = 9;
  localparam int unsigned COL_W   = 10;
  localparam int unsigned DEPTH_W = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned DIFF_W  = 18;
  localparam int unsigned PROD_W  = DIFF_W + DEPTH_W + 1;
  localparam int unsigned MAG_W   = 32;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned FRONT_LAT = 3;
  localparam int unsigned DIV_LAT   = MAG_W;

  localparam logic [CFG_W-1:0] FOCAL_X_RST  = 16'd9469;
  localparam logic [CFG_W-1:0] FOCAL_Y_RST  = 16'd9460;
  localparam logic [CFG_W-1:0] CENTER_X_RST = 16'd5068;
  localparam logic [CFG_W-1:0] CENTER_Y_RST = 16'd3993;

  typedef enum logic [IDX_W-1:0] {
    REG_FOCAL_X  = 3'd0,
    REG_FOCAL_Y  = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] focal_x;
    logic [CFG_W-1:0] focal_y;
    logic [CFG_W-1:0] center_x;
    logic [CFG_W-1:0] center_y;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic               neg_x;
    logic               zero_x;
    logic [MAG_W-1:0]   mag_x;
    logic               neg_y;
    logic               zero_y;
    logic [MAG_W-1:0]   mag_y;
    logic [DEPTH_W-1:0] z;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
  } front_t;

endpackage

// ===== hw/rtl/dpbp_front.sv =====
module dpbp_front #(
  parameter int FRAME_COLS = 640,
  parameter int FRAME_ROWS = 480
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [dpbp_pkg::ROW_W-1:0]    pixel_row,
  input  logic [dpbp_pkg::COL_W-1:0]    pixel_col,
  input  logic [dpbp_pkg::DEPTH_W-1:0]  depth_value,
  input  dpbp_pkg::cfg_t                cfg,
  output dpbp_pkg::front_t              front
);
  import dpbp_pkg::*;

  logic                      s1_valid_r, s2_valid_r, s3_valid_r;
  logic signed [DIFF_W-1:0]  dx_r, dy_r;
  logic [DEPTH_W-1:0]        z1_r, z2_r, z3_r;
  logic [ROW_W-1:0]          row1_r, row2_r, row3_r;
  logic [COL_W-1:0]          col1_r, col2_r, col3_r;
  logic signed [PROD_W-1:0]  px_r, py_r;
  logic                      neg_x_r, zero_x_r, neg_y_r, zero_y_r;
  logic [MAG_W-1:0]          mag_x_r, mag_y_r;

  logic                      s1_valid_nxt;
  logic signed [DIFF_W-1:0]  dx_nxt, dy_nxt;
  logic signed [PROD_W-1:0]  px_abs, py_abs;

  always_comb begin
    s1_valid_nxt = accept && (depth_value != '0)
                   && (int'(pixel_row) < FRAME_ROWS) && (int'(pixel_col) < FRAME_COLS);
    dx_nxt = $signed({4'b0, pixel_col, 4'b0}) - $signed({2'b0, cfg.center_x});
    dy_nxt = $signed({5'b0, pixel_row, 4'b0}) - $signed({2'b0, cfg.center_y});
    px_abs = px_r[PROD_W-1] ? -px_r : px_r;
    py_abs = py_r[PROD_W-1] ? -py_r : py_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    dx_r     <= dx_nxt;
    dy_r     <= dy_nxt;
    z1_r     <= depth_value;
    row1_r   <= pixel_row;
    col1_r   <= pixel_col;
    px_r     <= PROD_W'(dx_r) * PROD_W'($signed({1'b0, z1_r}));
    py_r     <= PROD_W'(dy_r) * PROD_W'($signed({1'b0, z1_r}));
    z2_r     <= z1_r;
    row2_r   <= row1_r;
    col2_r   <= col1_r;
    neg_x_r  <= px_r[PROD_W-1];
    zero_x_r <= (px_r == '0);
    mag_x_r  <= px_abs[MAG_W-1:0];
    neg_y_r  <= py_r[PROD_W-1];
    zero_y_r <= (py_r == '0);
    mag_y_r  <= py_abs[MAG_W-1:0];
    z3_r     <= z2_r;
    row3_r   <= row2_r;
    col3_r   <= col2_r;
  end

  always_comb begin
    front.valid  = s3_valid_r;
    front.neg_x  = neg_x_r;
    front.zero_x = zero_x_r;
    front.mag_x  = mag_x_r;
    front.neg_y  = neg_y_r;
    front.zero_y = zero_y_r;
    front.mag_y  = mag_y_r;
    front.z      = z3_r;
    front.row    = row3_r;
    front.col    = col3_r;
  end

endmodule

// ===== hw/rtl/dpbp_div.sv =====
module dpbp_div (
  input  logic                        clk,
  input  logic [dpbp_pkg::MAG_W-1:0]  dividend,
  input  logic [dpbp_pkg::CFG_W-1:0]  divisor,
  output logic [dpbp_pkg::MAG_W-1:0]  quotient
);
  import dpbp_pkg::*;

  logic [CFG_W-1:0] rem_r  [MAG_W];
  logic [MAG_W-1:0] work_r [MAG_W];

  for (genvar k = 0; k < MAG_W; k++) begin : g_stage
    logic [CFG_W-1:0] rem_in;
    logic [MAG_W-1:0] work_in;
    logic [CFG_W:0]   trial;
    logic [CFG_W:0]   diff;
    logic             fits;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign work_in = dividend;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign work_in = work_r[k-1];
    end

    assign trial = {rem_in, work_in[MAG_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge clk) begin
      rem_r[k]  <= fits ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
      work_r[k] <= {work_in[MAG_W-2:0], fits};
    end
  end

  assign quotient = work_r[MAG_W-1];

endmodule

// ===== hw/rtl/depth_pixel_back_projection.sv =====
// Depth pixel back-projection to a 3D point (pinhole camera).
// Input: pulse start with in_pixel_row, in_pixel_col and in_depth_value; a beat
// is taken at each clock edge where start is high and busy is low. busy is low
// from the first clock edge out of reset, so a pixel may be offered every clock.
// Output: out_valid strobes for one cycle with out_point_x/y/z, out_row and
// out_col. There is no back-pressure; the receiver must take every beat.
// A pixel with zero depth or outside the frame gives no output beat.
// From the accepted beat to its strobe a pixel passes three stages
// (offset, multiply, magnitude), a 32-stage restoring divider that retires one
// quotient bit per stage, and one saturation stage. Throughput is one pixel
// per clock; x and y run through separate dividers side by side.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Index 0 focal_x, 1 focal_y, 2 center_x, 3 center_y (Q12.4);
// other indexes are ignored. Write only while no pixel is in flight.
// Reset (synchronous, rst_n low) restores default intrinsics, drops all beats
// in flight and holds busy high.
`include "depth_pixel_back_projection_macros.svh"

module depth_pixel_back_projection #(
  parameter int FRAME_COLS = 640,
  parameter int FRAME_ROWS = 480
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [dpbp_pkg::ROW_W-1:0]          in_pixel_row,
  input  logic [dpbp_pkg::COL_W-1:0]          in_pixel_col,
  input  logic [dpbp_pkg::DEPTH_W-1:0]        in_depth_value,
  output logic                                out_valid,
  output logic signed [dpbp_pkg::COORD_W-1:0] out_point_x,
  output logic signed [dpbp_pkg::COORD_W-1:0] out_point_y,
  output logic [dpbp_pkg::DEPTH_W-1:0]        out_point_z,
  output logic [dpbp_pkg::ROW_W-1:0]          out_row,
  output logic [dpbp_pkg::COL_W-1:0]          out_col,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dpbp_pkg::IDX_W-1:0]          cfg_index,
  input  logic [dpbp_pkg::CFG_W-1:0]          cfg_data
);
  import dpbp_pkg::*;

  localparam int unsigned TOTAL_LAT = FRONT_LAT + DIV_LAT + 1;

  typedef struct packed {
    logic               neg_x;
    logic               zero_x;
    logic               neg_y;
    logic               zero_y;
    logic [DEPTH_W-1:0] z;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
  } side_t;

  cfg_t             cfg_r;
  logic             busy_r;
  front_t           front;
  logic [MAG_W-1:0] quot_x, quot_y;
  logic             side_vld_r [DIV_LAT];
  side_t            side_r     [DIV_LAT];
  logic             out_valid_r;
  logic [COORD_W-1:0] point_x_r, point_y_r;
  logic [DEPTH_W-1:0] point_z_r;
  logic [ROW_W-1:0]   row_r;
  logic [COL_W-1:0]   col_r;
  logic               accept;

  function automatic logic [COORD_W-1:0] saturate(input logic neg, input logic zero,
                                                  input logic [MAG_W-1:0] q);
    logic [COORD_W-1:0] res;
    if (zero) begin
      res = '0;
    end else if (!neg) begin
      res = q[MAG_W-1] ? {1'b0, {(COORD_W-1){1'b1}}} : q;
    end else if (q[MAG_W-1] && (q[MAG_W-2:0] != '0)) begin
      res = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      res = -q;
    end
    return res;
  endfunction

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r         <= 1'b1;
      cfg_r.focal_x  <= FOCAL_X_RST;
      cfg_r.focal_y  <= FOCAL_Y_RST;
      cfg_r.center_x <= CENTER_X_RST;
      cfg_r.center_y <= CENTER_Y_RST;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          REG_FOCAL_X:  cfg_r.focal_x  <= cfg_data;
          REG_FOCAL_Y:  cfg_r.focal_y  <= cfg_data;
          REG_CENTER_X: cfg_r.center_x <= cfg_data;
          REG_CENTER_Y: cfg_r.center_y <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  dpbp_front #(
    .FRAME_COLS(FRAME_COLS),
    .FRAME_ROWS(FRAME_ROWS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .pixel_row   (in_pixel_row),
    .pixel_col   (in_pixel_col),
    .depth_value (in_depth_value),
    .cfg         (cfg_r),
    .front       (front)
  );

  dpbp_div u_div_x (
    .clk      (clk),
    .dividend (front.mag_x),
    .divisor  (cfg_r.focal_x),
    .quotient (quot_x)
  );

  dpbp_div u_div_y (
    .clk      (clk),
    .dividend (front.mag_y),
    .divisor  (cfg_r.focal_y),
    .quotient (quot_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        side_vld_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else begin
      side_vld_r[0] <= front.valid;
      for (int k = 1; k < DIV_LAT; k++) begin
        side_vld_r[k] <= side_vld_r[k-1];
      end
      out_valid_r <= side_vld_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    side_r[0].neg_x  <= front.neg_x;
    side_r[0].zero_x <= front.zero_x;
    side_r[0].neg_y  <= front.neg_y;
    side_r[0].zero_y <= front.zero_y;
    side_r[0].z      <= front.z;
    side_r[0].row    <= front.row;
    side_r[0].col    <= front.col;
    for (int k = 1; k < DIV_LAT; k++) begin
      side_r[k] <= side_r[k-1];
    end
    point_x_r <= saturate(side_r[DIV_LAT-1].neg_x, side_r[DIV_LAT-1].zero_x, quot_x);
    point_y_r <= saturate(side_r[DIV_LAT-1].neg_y, side_r[DIV_LAT-1].zero_y, quot_y);
    point_z_r <= side_r[DIV_LAT-1].z;
    row_r     <= side_r[DIV_LAT-1].row;
    col_r     <= side_r[DIV_LAT-1].col;
  end

  assign out_valid   = out_valid_r;
  assign out_point_x = point_x_r;
  assign out_point_y = point_y_r;
  assign out_point_z = point_z_r;
  assign out_row     = row_r;
  assign out_col     = col_r;

  `DPBP_ASSERT_NOW(a_strobe_has_depth, clk, rst_n, out_valid, out_point_z != '0, "output beat with zero depth")
  `DPBP_ASSERT_NOW(a_strobe_from_accept, clk, rst_n, out_valid, $past(start && !busy, TOTAL_LAT), "output beat without matching input beat")
  `DPBP_ASSERT_NOW(a_strobe_in_frame, clk, rst_n, out_valid, (int'(out_row) < FRAME_ROWS) && (int'(out_col) < FRAME_COLS), "output beat outside frame")
  `DPBP_ASSERT_NEXT(a_zero_depth_drops, clk, rst_n, start && !busy && (in_depth_value == '0), !u_front.s1_valid_r, "zero depth beat entered pipeline")

endmodule

// ===== sim/point_checker.sv =====
module point_checker #(
  parameter int FRAME_COLS = 640,
  parameter int FRAME_ROWS = 480
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  logic [dpbp_pkg::ROW_W-1:0]          in_pixel_row,
  input  logic [dpbp_pkg::COL_W-1:0]          in_pixel_col,
  input  logic [dpbp_pkg::DEPTH_W-1:0]        in_depth_value,
  input  logic                                out_valid,
  input  logic signed [dpbp_pkg::COORD_W-1:0] out_point_x,
  input  logic signed [dpbp_pkg::COORD_W-1:0] out_point_y,
  input  logic [dpbp_pkg::DEPTH_W-1:0]        out_point_z,
  input  logic [dpbp_pkg::ROW_W-1:0]          out_row,
  input  logic [dpbp_pkg::COL_W-1:0]          out_col,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [dpbp_pkg::IDX_W-1:0]          cfg_index,
  input  logic [dpbp_pkg::CFG_W-1:0]          cfg_data,
  output int                                  mismatches,
  output int                                  points_pending
);
  import dpbp_pkg::*;

  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;
  localparam int     SHOWN_MAX = 10;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [DEPTH_W-1:0]        z;
    logic [ROW_W-1:0]          row;
    logic [COL_W-1:0]          col;
  } point_t;

  point_t           expected_points[$];
  logic [CFG_W-1:0] focal_x;
  logic [CFG_W-1:0] focal_y;
  logic [CFG_W-1:0] center_x;
  logic [CFG_W-1:0] center_y;

  function automatic logic signed [COORD_W-1:0] back_project(
    input int unsigned      pix,
    input logic [CFG_W-1:0] center,
    input logic [CFG_W-1:0] focal,
    input logic [DEPTH_W-1:0] depth
  );
    longint numer;
    longint quot;
    numer = (longint'(pix) * 16 - longint'(center)) * longint'(depth);
    if (focal == '0) begin
      quot = (numer > 0) ? COORD_MAX : ((numer < 0) ? COORD_MIN : 64'sd0);
    end else begin
      quot = numer / longint'(focal);
      if (quot > COORD_MAX) quot = COORD_MAX;
      if (quot < COORD_MIN) quot = COORD_MIN;
    end
    return quot[COORD_W-1:0];
  endfunction

  always @(posedge clk) begin
    point_t seen;
    point_t want;
    if (!rst_n) begin
      focal_x        <= FOCAL_X_RST;
      focal_y        <= FOCAL_Y_RST;
      center_x       <= CENTER_X_RST;
      center_y       <= CENTER_Y_RST;
      expected_points.delete();
      mismatches     <= 0;
      points_pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FOCAL_X:  focal_x  <= cfg_data;
          REG_FOCAL_Y:  focal_y  <= cfg_data;
          REG_CENTER_X: center_x <= cfg_data;
          REG_CENTER_Y: center_y <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid) begin
        seen.x   = out_point_x;
        seen.y   = out_point_y;
        seen.z   = out_point_z;
        seen.row = out_row;
        seen.col = out_col;
        if (expected_points.size() == 0) begin
          if (mismatches < SHOWN_MAX)
            $display("unexpected point: x=%0d y=%0d z=%0d row=%0d col=%0d",
                     seen.x, seen.y, seen.z, seen.row, seen.col);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_points.pop_front();
          if (seen.x !== want.x || seen.y !== want.y || seen.z !== want.z ||
              seen.row !== want.row || seen.col !== want.col) begin
            if (mismatches < SHOWN_MAX)
              $display({"point mismatch: expected x=%0d y=%0d z=%0d row=%0d col=%0d,",
                        " got x=%0d y=%0d z=%0d row=%0d col=%0d"},
                       want.x, want.y, want.z, want.row, want.col,
                       seen.x, seen.y, seen.z, seen.row, seen.col);
            mismatches <= mismatches + 1;
          end
        end
      end

      if (start && !busy && in_depth_value != '0 &&
          int'(in_pixel_row) < FRAME_ROWS && int'(in_pixel_col) < FRAME_COLS) begin
        want.x   = back_project(in_pixel_col, center_x, focal_x, in_depth_value);
        want.y   = back_project(in_pixel_row, center_y, focal_y, in_depth_value);
        want.z   = in_depth_value;
        want.row = in_pixel_row;
        want.col = in_pixel_col;
        expected_points.insert(expected_points.size(), want);
      end

      points_pending <= expected_points.size();
    end
  end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  import dpbp_pkg::*;

  localparam int FRAME_COLS     = 640;
  localparam int FRAME_ROWS     = 480;
  localparam int SETTLE_CYCLES  = FRONT_LAT + DIV_LAT + 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 100;
  localparam logic [IDX_W-1:0] FIRST_UNUSED_IDX = IDX_W'(REG_CENTER_Y) + 1'b1;
  localparam logic [IDX_W-1:0] LAST_UNUSED_IDX  = '1;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [ROW_W-1:0]          in_pixel_row;
  logic [COL_W-1:0]          in_pixel_col;
  logic [DEPTH_W-1:0]        in_depth_value;
  logic                      out_valid;
  logic signed [COORD_W-1:0] out_point_x;
  logic signed [COORD_W-1:0] out_point_y;
  logic [DEPTH_W-1:0]        out_point_z;
  logic [ROW_W-1:0]          out_row;
  logic [COL_W-1:0]          out_col;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [IDX_W-1:0]          cfg_index;
  logic [CFG_W-1:0]          cfg_data;
  int                        mismatches;
  int                        points_pending;
  int                        sender_idle_pct;
  int                        quiet_cycles;

  depth_pixel_back_projection #(
    .FRAME_COLS(FRAME_COLS),
    .FRAME_ROWS(FRAME_ROWS)
  ) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_pixel_row(in_pixel_row), .in_pixel_col(in_pixel_col),
    .in_depth_value(in_depth_value),
    .out_valid(out_valid), .out_point_x(out_point_x), .out_point_y(out_point_y),
    .out_point_z(out_point_z), .out_row(out_row), .out_col(out_col),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  point_checker #(
    .FRAME_COLS(FRAME_COLS),
    .FRAME_ROWS(FRAME_ROWS)
  ) points (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_pixel_row(in_pixel_row), .in_pixel_col(in_pixel_col),
    .in_depth_value(in_depth_value),
    .out_valid(out_valid), .out_point_x(out_point_x), .out_point_y(out_point_y),
    .out_point_z(out_point_z), .out_row(out_row), .out_col(out_col),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatches(mismatches), .points_pending(points_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic drive_pixel(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                             input logic [DEPTH_W-1:0] depth);
    while (int'($urandom_range(99)) < sender_idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start          <= 1'b1;
    in_pixel_row   <= row;
    in_pixel_col   <= col;
    in_depth_value <= depth;
    do @(posedge clk); while (busy);
  endtask

  task automatic random_pixel();
    int kind;
    kind = $urandom_range(99);
    if (kind < 10) begin
      drive_pixel(ROW_W'($urandom_range(FRAME_ROWS - 1)),
                  COL_W'($urandom_range(FRAME_COLS - 1)), '0);
    end else if (kind < 16) begin
      if ($urandom_range(1))
        drive_pixel(ROW_W'($urandom_range(FRAME_ROWS, 511)), COL_W'($urandom()),
                    DEPTH_W'($urandom()));
      else
        drive_pixel(ROW_W'($urandom()), COL_W'($urandom_range(FRAME_COLS, 1023)),
                    DEPTH_W'($urandom()));
    end else begin
      drive_pixel(ROW_W'($urandom_range(FRAME_ROWS - 1)),
                  COL_W'($urandom_range(FRAME_COLS - 1)),
                  DEPTH_W'($urandom_range(1, 65535)));
    end
  endtask

  // hold off until every point is out and zero-depth beats have left the pipe
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (points_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_intrinsics(input logic [CFG_W-1:0] fx, input logic [CFG_W-1:0] fy,
                                  input logic [CFG_W-1:0] cx, input logic [CFG_W-1:0] cy);
    write_reg(REG_FOCAL_X, fx);
    write_reg(REG_FOCAL_Y, fy);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    if ($urandom_range(1))
      write_reg(IDX_W'($urandom_range(FIRST_UNUSED_IDX, LAST_UNUSED_IDX)),
                CFG_W'($urandom()));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] random_focal();
    int pick;
    pick = $urandom_range(99);
    if (pick < 5)  return '0;
    if (pick < 15) return CFG_W'($urandom_range(1, 15));
    if (pick < 25) return CFG_W'($urandom_range(16, 255));
    return CFG_W'($urandom_range(16, 65535));
  endfunction

  initial begin
    int idle_plan[4];
    idle_plan = '{0, 52, 0, 7};
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_pixel_row    <= '0;
    in_pixel_col    <= '0;
    in_depth_value  <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    sender_idle_pct  = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset intrinsics: corners, zero depth, pixels off the frame
    drive_pixel(0, 0, 1);
    drive_pixel(479, 639, 16'hFFFF);
    drive_pixel(0, 0, 16'hFFFF);
    drive_pixel(240, 320, 1000);
    drive_pixel(100, 100, 0);
    drive_pixel(480, 10, 500);
    drive_pixel(511, 1023, 16'hFFFF);
    drive_pixel(10, 640, 77);
    drain();

    // zero focal in x, unit focal in y: saturation both ways
    apply_intrinsics('0, 16'd1, '0, 16'hFFFF);
    write_reg(FIRST_UNUSED_IDX, 16'h1234);
    write_reg(LAST_UNUSED_IDX, 16'hFFFF);
    @(negedge clk);
    cfg_valid <= 1'b0;
    drive_pixel(0, 0, 500);
    drive_pixel(479, 639, 16'hFFFF);
    drive_pixel(0, 5, 100);
    drive_pixel(300, 0, 1);
    drain();

    // widest focal in x, zero focal in y, center x at the top of the range, center y zero
    apply_intrinsics(16'hFFFF, '0, 16'hFFFF, '0);
    drive_pixel(479, 0, 16'hFFFF);
    drive_pixel(0, 639, 1);
    drive_pixel(0, 639, 2);
    drive_pixel(0, 0, 3);
    drive_pixel(1, 1, 16'h8000);
    drain();

    apply_intrinsics(16'hFFFF, 16'hFFFF, '0, '0);
    drive_pixel(479, 639, 16'hFFFF);
    drive_pixel(256, 512, 16'h5555);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      apply_intrinsics(random_focal(), random_focal(), CFG_W'($urandom()), CFG_W'($urandom()));
      sender_idle_pct = idle_plan[phase];
      repeat (PHASE_ITEMS) random_pixel();
      drain();
    end

    if (mismatches == 0 && points_pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/dpbp_pkg.sv
hw/rtl/dpbp_front.sv
hw/rtl/dpbp_div.sv
hw/rtl/depth_pixel_back_projection.sv
sim/point_checker.sv
sim/tb_top.sv
